// ===== hdl/htfd_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// htfd_pkg
// Shared types, constants and the byte-wide CRC-8 function of the
// humidity and temperature frame decoder.
// ---------------------------------------------------------------------------
package htfd_pkg;

    // frame layout
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned POS_W      = 3;
    localparam int unsigned RAW_W      = 20;
    localparam int unsigned CENTI_W    = 15;
    localparam int unsigned DATA_OUT_W = 80;

    localparam logic [POS_W-1:0] POS_FIRST = 3'd0;
    localparam logic [POS_W-1:0] POS_HUM_HI  = 3'd1;
    localparam logic [POS_W-1:0] POS_HUM_MID = 3'd2;
    localparam logic [POS_W-1:0] POS_SPLIT   = 3'd3;
    localparam logic [POS_W-1:0] POS_TEMP_MID = 3'd4;
    localparam logic [POS_W-1:0] POS_TEMP_LO  = 3'd5;
    localparam logic [POS_W-1:0] POS_CRC     = 3'd6;
    localparam logic [POS_W-1:0] POS_INVALID = 3'd7;

    // crc-8, msb first, no final xor
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // scaling: value = (raw * scale) >> 20, temperature then offset
    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic [14:0] TEMP_SCALE  = 15'd20000;
    localparam logic signed [15:0] TEMP_OFFSET = 16'sd5000;
    localparam logic signed [CENTI_W-1:0] ERROR_CENTI = -15'sd100;

    // result status carried on tuser
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CRC_ERR = 2'd1,
        ST_BUS_ERR = 2'd2
    } status_t;

    // input flags carried on tuser
    typedef struct packed {
        logic read_error;
        logic frame_start;
    } in_flags_t;

    // one crc-8 update over a whole byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/humidity_temp_frame_decoder.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// humidity_temp_frame_decoder
// Decodes seven-byte humidity/temperature sensor frames with a CRC-8 check.
// ---------------------------------------------------------------------------
// Takes one frame byte per item, one item per clock cycle while the result
// side is not stalled. Byte zero (status) through byte five feed a running
// CRC-8 (poly 0x31, init 0xFF); bytes one to five hold the 20-bit raw
// humidity and temperature fields. The seventh byte is compared against the
// CRC and produces one result item; a read_error item produces an error
// result at once and restarts the frame. Every item passes an input register
// and then the decode logic into a result register before its result shows
// on the m_ side. The decode stage holds one 20x14 and one 20x15 constant
// multiplier. A stalled result holds the pipe, and s_tready then follows
// m_tready once the input register is full.
module humidity_temp_frame_decoder (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input channel
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [htfd_pkg::BYTE_W-1:0]       s_tdata,  // [7:0] rx_byte
    input  wire logic [1:0]                        s_tuser,  // [0] frame_start, [1] read_error
    // result channel
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [14:0] humidity_centi, [29:15] temperature_centi, [49:30] hum_raw,
    // [69:50] temp_raw, [77:70] crc_computed, [79:78] zero
    output logic [htfd_pkg::DATA_OUT_W-1:0]        m_tdata,
    output logic [1:0]                             m_tuser   // [1:0] status
);
    import htfd_pkg::*;

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    in_flags_t         in_flags_reg;

    // frame state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       crc_reg, crc_next;
    logic [RAW_W-1:0] hum_reg, hum_next;
    logic [RAW_W-1:0] temp_reg, temp_next;

    // result register
    logic                       out_valid_reg, out_valid_next;
    logic signed [CENTI_W-1:0]  out_hum_reg, out_hum_next;
    logic signed [CENTI_W-1:0]  out_temp_reg, out_temp_next;
    status_t                    out_status_reg, out_status_next;
    logic [RAW_W-1:0]           out_raw_hum_reg, out_raw_hum_next;
    logic [RAW_W-1:0]           out_raw_temp_reg, out_raw_temp_next;
    logic [7:0]                 out_crc_reg, out_crc_next;

    logic advance;
    logic consume;
    logic restart;
    logic [POS_W-1:0] pos_eff;
    logic [7:0]       crc_base;
    logic [7:0]       crc_upd;
    logic [33:0]      hum_prod;
    logic [34:0]      temp_prod;
    logic signed [15:0] temp_wide;

    // pipe moves when the result register is free or being taken
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign consume  = in_valid_reg && advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_byte_reg  <= s_tdata;
            in_flags_reg <= in_flags_t'(s_tuser);
        end
    end

    // scaling of the assembled raw fields
    assign hum_prod  = 34'(hum_reg) * 34'(HUM_SCALE);
    assign temp_prod = 35'(temp_reg) * 35'(TEMP_SCALE);
    assign temp_wide = $signed({1'b0, temp_prod[34:20]}) - TEMP_OFFSET;

    // position and crc seen by this byte
    assign restart  = in_flags_reg.frame_start || (pos_reg == POS_INVALID);
    assign pos_eff  = restart ? POS_FIRST : pos_reg;
    assign crc_base = restart ? CRC_INIT : crc_reg;
    assign crc_upd  = crc8_byte(crc_base, in_byte_reg);

    // frame decode
    always_comb begin
        pos_next          = pos_reg;
        crc_next          = crc_reg;
        hum_next          = hum_reg;
        temp_next         = temp_reg;
        out_valid_next    = m_tready ? 1'b0 : out_valid_reg;
        out_hum_next      = out_hum_reg;
        out_temp_next     = out_temp_reg;
        out_status_next   = out_status_reg;
        out_raw_hum_next  = out_raw_hum_reg;
        out_raw_temp_next = out_raw_temp_reg;
        out_crc_next      = out_crc_reg;

        if (consume) begin
            if (in_flags_reg.read_error) begin
                // bus error: abort frame, report at once
                pos_next          = POS_FIRST;
                crc_next          = CRC_INIT;
                hum_next          = '0;
                temp_next         = '0;
                out_valid_next    = 1'b1;
                out_hum_next      = ERROR_CENTI;
                out_temp_next     = ERROR_CENTI;
                out_status_next   = ST_BUS_ERR;
                out_raw_hum_next  = '0;
                out_raw_temp_next = '0;
                out_crc_next      = '0;
            end else if (pos_eff == POS_CRC) begin
                // crc byte: check and report
                pos_next          = POS_FIRST;
                crc_next          = CRC_INIT;
                out_valid_next    = 1'b1;
                out_raw_hum_next  = hum_reg;
                out_raw_temp_next = temp_reg;
                out_crc_next      = crc_base;
                if (crc_base == in_byte_reg) begin
                    out_hum_next    = $signed({1'b0, hum_prod[33:20]});
                    out_temp_next   = temp_wide[CENTI_W-1:0];
                    out_status_next = ST_OK;
                end else begin
                    out_hum_next    = ERROR_CENTI;
                    out_temp_next   = ERROR_CENTI;
                    out_status_next = ST_CRC_ERR;
                end
            end else begin
                // data byte: crc and field capture
                pos_next = pos_eff + 3'd1;
                crc_next = crc_upd;
                case (pos_eff)
                    POS_HUM_HI:   hum_next[19:12] = in_byte_reg;
                    POS_HUM_MID:  hum_next[11:4]  = in_byte_reg;
                    POS_SPLIT: begin
                        hum_next[3:0]    = in_byte_reg[7:4];
                        temp_next[19:16] = in_byte_reg[3:0];
                    end
                    POS_TEMP_MID: temp_next[15:8] = in_byte_reg;
                    POS_TEMP_LO:  temp_next[7:0]  = in_byte_reg;
                    default: ;
                endcase
            end
        end
    end

    // frame state and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= POS_FIRST;
            crc_reg       <= CRC_INIT;
            hum_reg       <= '0;
            temp_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            hum_reg       <= hum_next;
            temp_reg      <= temp_next;
            out_valid_reg <= out_valid_next;
        end
        out_hum_reg      <= out_hum_next;
        out_temp_reg     <= out_temp_next;
        out_status_reg   <= out_status_next;
        out_raw_hum_reg  <= out_raw_hum_next;
        out_raw_temp_reg <= out_raw_temp_next;
        out_crc_reg      <= out_crc_next;
    end

    // result channel
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {2'b00, out_crc_reg, out_raw_temp_reg, out_raw_hum_reg,
                       out_temp_reg, out_hum_reg};

endmodule
`default_nettype wire

// ===== hdl/htfd_port_checker.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// htfd_port_checker
// Port-level checks of the frame decoder, bound to the top level.
// ---------------------------------------------------------------------------
module htfd_port_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [htfd_pkg::DATA_OUT_W-1:0]   m_tdata,
    input wire logic [1:0]                        m_tuser
);
    import htfd_pkg::*;

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // no result right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result shown after reset");

    // any error status reports -100 on both values
    a_error_values: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_CRC_ERR || m_tuser == ST_BUS_ERR) |->
            m_tdata[14:0] == ERROR_CENTI && m_tdata[29:15] == ERROR_CENTI)
        else $error("error result without -100 values");

    // bus error clears raw fields and crc, padding always zero
    a_bus_error_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_BUS_ERR |-> m_tdata[79:30] == '0)
        else $error("bus error result carries raw data");

    // an ok result never shows negative humidity, and its padding is zero
    a_ok_humidity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_OK |-> !m_tdata[14] && m_tdata[79:78] == 2'b00)
        else $error("ok result with negative humidity");

endmodule

bind humidity_temp_frame_decoder htfd_port_checker u_htfd_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
